### hw/rtl/ipd_pkg.sv
package ipd_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned GRID_W_W   = 7;
  localparam int unsigned GRID_H_W   = 13;
  localparam int unsigned ENTRY_W    = 2;

  localparam logic [GRID_W_W-1:0] GRID_W_RESET = 7'd64;
  localparam logic [GRID_H_W-1:0] GRID_H_RESET = 13'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

### hw/rtl/ipd_ram.sv
module ipd_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]                        rdata_a_o,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                        rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### hw/rtl/isolated_pixel_detector_top.sv
// Checks a binary image, streamed in raster order one pixel per request, for set
// pixels that have no set up, down, left or right neighbour inside the grid. One
// verdict (all_supported_o = 1 when no isolated set pixel was found) is issued on
// the last pixel of each frame, in the cycle after that pixel is taken; all other
// pixels produce nothing. The block takes one pixel per clock: the previous two
// rows live in a two-read-port RAM whose registered reads are addressed one pixel
// ahead, so the check itself is combinational. Input stalls only while a verdict
// is pending and the next pixel would issue another, and while the RAM is read
// anew after a mid-frame register write moves the current column. Width and height
// registers read as 1 when zero and saturate at MAX_WIDTH and MAX_HEIGHT.
module isolated_pixel_detector_top
  import ipd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  pixel_set_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  all_supported_o
);

  localparam int unsigned CW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;

  logic [GRID_W_W-1:0] grid_w_q;
  logic [GRID_H_W-1:0] grid_h_q;
  logic [CW-1:0]       col_q, col_d, w_m1, col;
  logic [RW-1:0]       row_q, row_d, h_m1, row;
  logic [ENTRY_W-1:0]  recent_q, recent_d;
  logic                viol_q, viol_d;
  logic                prev_up_q;
  logic                out_valid_q, out_valid_d;
  logic                result_q, result_d;
  logic [CW-1:0]       raddr_q, raddr_d;
  logic                fetch_q, fetch_d, load_up;
  logic                hit_a_q, hit_b_q;
  entry_t              byp_q;
  entry_t              ram_a, ram_b, cur, nxt, wr_entry;
  logic                last_col, last_row, emit, accept;
  logic                bad_up, bad_left, bad_self, bad;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= GRID_W_RESET;
      grid_h_q <= GRID_H_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_WIDTH:  grid_w_q <= cfg_data_i[GRID_W_W-1:0];
        CFG_GRID_HEIGHT: grid_h_q <= cfg_data_i[GRID_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_w_q == '0) begin
      w_m1 = '0;
    end else if (32'(grid_w_q) > 32'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(grid_w_q - 7'd1);
    end
    if (grid_h_q == '0) begin
      h_m1 = '0;
    end else if (32'(grid_h_q) > 32'(MAX_HEIGHT)) begin
      h_m1 = RW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = RW'(grid_h_q - 13'd1);
    end
  end

  assign col      = (col_q > w_m1) ? w_m1 : col_q;
  assign row      = (row_q > h_m1) ? h_m1 : row_q;
  assign last_col = (col == w_m1);
  assign last_row = (row == h_m1);
  assign emit     = last_col && last_row;

  assign in_ready_o = (raddr_q == col) && !fetch_q &&
                      (!emit || !out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign cur      = hit_a_q ? byp_q : ram_a;
  assign nxt      = hit_b_q ? byp_q : ram_b;
  assign wr_entry = {cur[0], pixel_set_i};

  always_comb begin
    bad_up = (32'(row) >= 32'd1) && cur[0] &&
             !(((32'(row) >= 32'd2) && cur[1]) || pixel_set_i ||
               ((col != '0) && prev_up_q) || (!last_col && nxt[0]));
    bad_left = last_row && (col != '0) && recent_q[0] &&
               !(((32'(col) >= 32'd2) && recent_q[1]) ||
                 ((row != '0) && prev_up_q) || pixel_set_i);
    bad_self = emit && pixel_set_i &&
               !(((col != '0) && recent_q[0]) || ((row != '0) && cur[0]));
    bad = bad_up || bad_left || bad_self;
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    recent_d    = recent_q;
    viol_d      = viol_q;
    out_valid_d = out_valid_q && !out_ready_i;
    result_d    = result_q;
    if (accept) begin
      col_d    = last_col ? '0 : col + CW'(1);
      row_d    = last_col ? (last_row ? '0 : row + RW'(1)) : row;
      recent_d = last_col ? '0 : {recent_q[0], pixel_set_i};
      viol_d   = emit ? 1'b0 : (viol_q || bad);
      if (emit) begin
        out_valid_d = 1'b1;
        result_d    = !(viol_q || bad);
      end
    end
    // refetch the left column's upper pixel when the column moved without a request
    raddr_d = col;
    fetch_d = 1'b0;
    load_up = 1'b0;
    if (accept) begin
      raddr_d = col_d;
    end else if (fetch_q && (raddr_q == col - CW'(1))) begin
      load_up = 1'b1;
    end else if ((raddr_q != col) || fetch_q) begin
      raddr_d = col - CW'(1);
      fetch_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      recent_q    <= '0;
      viol_q      <= 1'b0;
      out_valid_q <= 1'b0;
      raddr_q     <= '0;
      fetch_q     <= 1'b0;
      hit_a_q     <= 1'b0;
      hit_b_q     <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      recent_q    <= recent_d;
      viol_q      <= viol_d;
      out_valid_q <= out_valid_d;
      raddr_q     <= raddr_d;
      fetch_q     <= fetch_d;
      hit_a_q     <= accept && (raddr_d == col);
      hit_b_q     <= accept && ((raddr_d + CW'(1)) == col);
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (accept) begin
      prev_up_q <= cur[0];
      byp_q     <= wr_entry;
    end else if (load_up) begin
      prev_up_q <= ram_a[1];
    end
  end

  ipd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (col),
    .wdata_i   (wr_entry),
    .raddr_a_i (raddr_d),
    .rdata_a_o (ram_a),
    .raddr_b_i (raddr_d + CW'(1)),
    .rdata_b_o (ram_b)
  );

  assign out_valid_o     = out_valid_q;
  assign all_supported_o = result_q;

endmodule

### sim/isolated_pixel_detector_top_test.sv
module isolated_pixel_detector_top_test;
  import ipd_pkg::*;

  localparam int unsigned MAX_W       = 64;
  localparam int unsigned MAX_H       = 4096;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_PIXELS = 1400;

  class verdict_board;
    logic [GRID_W_W-1:0] width_reg;
    logic [GRID_H_W-1:0] height_reg;
    logic [1:0]          column_bits [MAX_W];
    logic [1:0]          trail;
    int unsigned         col;
    int unsigned         row;
    bit                  flagged;
    bit                  expected_verdicts [$];
    int unsigned         errors;

    function new();
      width_reg  = GRID_W_RESET;
      height_reg = GRID_H_RESET;
      foreach (column_bits[i]) column_bits[i] = 2'b00;
      trail   = 2'b00;
      col     = 0;
      row     = 0;
      flagged = 1'b0;
      errors  = 0;
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void note_config(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH:  width_reg = data[GRID_W_W-1:0];
        CFG_GRID_HEIGHT: height_reg = data[GRID_H_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction

    function bit frame_start();
      return col == 0 && row == 0;
    endfunction

    function void note_pixel(bit p);
      int unsigned w, h, c, r;
      bit          last_col, last_row, bad, up, left, right;
      logic [1:0]  prev;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      c = (col > w - 1) ? w - 1 : col;
      r = (row > h - 1) ? h - 1 : row;
      last_col = (c == w - 1);
      last_row = (r == h - 1);
      prev = column_bits[c];
      bad = 1'b0;
      // judge the pixel above: its lower neighbour just arrived
      if (r >= 1) begin
        up    = (r >= 2) ? prev[1] : 1'b0;
        left  = (c > 0) ? column_bits[c-1][1] : 1'b0;
        right = !last_col ? column_bits[c+1][0] : 1'b0;
        bad = bad | (prev[0] & !(up | p | left | right));
      end
      column_bits[c] = {prev[0], p};
      // bottom row: judge along the row
      if (last_row) begin
        if (c >= 1) begin
          left = (c >= 2) ? trail[1] : 1'b0;
          up   = (r >= 1) ? column_bits[c-1][1] : 1'b0;
          bad = bad | (trail[0] & !(up | left | p));
        end
        if (last_col) begin
          left = (c >= 1) ? trail[0] : 1'b0;
          up   = (r >= 1) ? prev[0] : 1'b0;
          bad = bad | (p & !(up | left));
        end
      end
      trail = {trail[0], p};
      if (bad) flagged = 1'b1;
      if (!last_col) begin
        col = c + 1;
        row = r;
        return;
      end
      col   = 0;
      trail = 2'b00;
      if (!last_row) begin
        row = r + 1;
        return;
      end
      expected_verdicts.push_back(!flagged);
      row     = 0;
      flagged = 1'b0;
    endfunction

    function void check_verdict(logic actual);
      bit exp_v;
      if (expected_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("verdict %0b with none expected", actual);
        return;
      end
      exp_v = expected_verdicts.pop_front();
      if (actual !== exp_v) begin
        errors++;
        if (errors <= 10) $display("verdict mismatch: expected %0b, got %0b", exp_v, actual);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  pixel_set_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  all_supported_o;

  verdict_board board;
  int unsigned  cycle_count  = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  pixels_sent  = 0;
  logic         steady;

  assign steady = (cycle_count % 8000) < 1500;

  isolated_pixel_detector_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_set_i    (pixel_set_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .all_supported_o(all_supported_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_ready_i <= steady || ($urandom_range(0, 99) >= 25);
    if (rst_ni && out_valid_o && out_ready_i) board.check_verdict(all_supported_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(bit p);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_set_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pixel(p);
    pixels_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.note_config(idx, data);
  endtask

  task automatic set_grid(logic [CFG_DATA_W-1:0] wd, logic [CFG_DATA_W-1:0] hd);
    drain();
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_GRID_WIDTH, wd);
      write_reg(CFG_GRID_HEIGHT, hd);
    end else begin
      write_reg(CFG_GRID_HEIGHT, hd);
      write_reg(CFG_GRID_WIDTH, wd);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_bits(int unsigned n, logic [63:0] bits);
    for (int unsigned i = 0; i < n; i++) send_pixel(bits[i]);
  endtask

  task automatic send_frame(int unsigned w, int unsigned h, int unsigned stop_at);
    bit          img [];
    int unsigned n, density, style;
    bit          nb;
    n = w * h;
    img = new[n];
    density = $urandom_range(5, 70);
    style = $urandom_range(0, 3);
    for (int unsigned k = 0; k < n; k++) img[k] = ($urandom_range(0, 99) < density);
    // drop isolated pixels so most frames pass, then maybe break one spot
    if (style != 0) begin
      for (int unsigned y = 0; y < h; y++) begin
        for (int unsigned x = 0; x < w; x++) begin
          nb = (x > 0 && img[y*w+x-1]) || (x + 1 < w && img[y*w+x+1]) ||
               (y > 0 && img[(y-1)*w+x]) || (y + 1 < h && img[(y+1)*w+x]);
          if (!nb) img[y*w+x] = 1'b0;
        end
      end
    end
    if (style == 3) img[$urandom_range(0, n - 1)] ^= 1'b1;
    for (int unsigned k = 0; k < n && k < stop_at; k++) send_pixel(img[k]);
  endtask

  initial begin
    int unsigned w_raw, h_raw, w_eff, h_eff, frames, target;
    logic [5:0]  junk;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_grid(13'd1, 13'd1);
    send_bits(2, 64'b01);
    set_grid(13'd0, 13'd0);
    send_bits(1, 64'b1);
    set_grid(13'd2, 13'd1);
    send_bits(4, 64'b0111);
    set_grid(13'd1, 13'd2);
    send_bits(2, 64'b11);
    set_grid(13'd3, 13'd3);
    send_bits(9, 64'b000010000);
    send_bits(9, 64'b110000011);

    // saturated height on a one-pixel-wide grid, cut short by a height write
    set_grid({6'h3F, 7'd1}, 13'h1FFF);
    for (int unsigned i = 0; i < 300; i++) send_pixel(1'b1);
    drain();
    write_reg(CFG_GRID_HEIGHT, 13'd40);
    cfg_valid_i <= 1'b0;
    while (!board.frame_start()) send_pixel(1'b1);

    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      case ($urandom_range(0, 9))
        0:       w_raw = 0;
        1:       w_raw = $urandom_range(65, 127);
        2:       w_raw = 64;
        3:       w_raw = $urandom_range(9, 63);
        default: w_raw = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       h_raw = 0;
        1:       h_raw = $urandom_range(9, 40);
        default: h_raw = $urandom_range(1, 8);
      endcase
      w_eff = verdict_board::clamp_dim(w_raw, MAX_W);
      if (w_eff * verdict_board::clamp_dim(h_raw, MAX_H) > 600) h_raw = $urandom_range(1, 4);
      h_eff = verdict_board::clamp_dim(h_raw, MAX_H);
      junk = 6'($urandom_range(0, 63));
      set_grid({junk, 7'(w_raw)}, 13'(h_raw));
      frames = $urandom_range(1, 4);
      for (int unsigned f = 0; f < frames && pixels_sent < target; f++) begin
        send_frame(w_eff, h_eff, w_eff * h_eff);
      end
      // shrink or retarget the grid partway through a frame
      if ($urandom_range(0, 5) == 0 && w_eff * h_eff > 1) begin
        send_frame(w_eff, h_eff, $urandom_range(1, w_eff * h_eff - 1));
        drain();
        junk = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 1)) write_reg(CFG_GRID_WIDTH, {junk, 7'($urandom_range(0, w_eff))});
        else write_reg(CFG_GRID_HEIGHT, 13'($urandom_range(0, h_eff + 3)));
        cfg_valid_i <= 1'b0;
        while (!board.frame_start()) send_pixel($urandom_range(0, 1));
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### isolated_pixel_detector_top.f
hw/rtl/ipd_pkg.sv
hw/rtl/ipd_ram.sv
hw/rtl/isolated_pixel_detector_top.sv
sim/isolated_pixel_detector_top_test.sv
